// ===== sv/tdps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdps_pkg
// Shared types and constants for the tolerance dedup point set.
// ----------------------------------------------------------------------------
package tdps_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int COORD_W  = 32;
    localparam int RAD_W    = 31;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SUM_W    = SQ_W + 2;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TOLERANCE = 1'b0;

    // request types
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // result status codes
    localparam logic [2:0] STATUS_STORED    = 3'd0;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [2:0] STATUS_FULL      = 3'd2;
    localparam logic [2:0] STATUS_READ_OK   = 3'd3;
    localparam logic [2:0] STATUS_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic        [RAD_W-1:0]   radius_in;
        logic        [7:0]         read_index;
    } t_in_item;

    typedef struct packed {
        logic        [2:0]         status;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic        [RAD_W-1:0]   out_radius;
        logic        [8:0]         entry_count;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [RAD_W-1:0]   r;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller -> datapath
    typedef struct packed {
        logic             start;
        logic             rd_en;
        logic             scan;
        logic [IDX_W-1:0] scan_addr;
        logic             load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             pipe_busy;
        logic             out_free;
        logic             req_is_read;
        logic             read_in_range;
    } t_stat;

endpackage

// ===== sv/tolerance_dedup_point_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerance_dedup_point_set
// Near-duplicate filter over a table of (x, y, radius) points, Q16.16.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall  o_out_data (t_out_item)
//  cfg       input      APB psel/penable/pready    paddr, pwdata, prdata
//
//  Insert: the single table read port supplies one entry per cycle for each
//  of the n stored entries, then a 4-stage compare drains before the result.
//  Read: one table read. One request in flight; the next is taken while a
//  result waits in the output register. Reset clears the count, tolerance
//  and output valid, with no clearing pass over the table. An output stall
//  holds the result and then the next one.
// ----------------------------------------------------------------------------
module tolerance_dedup_point_set (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  tdps_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output tdps_pkg::t_out_item                   o_out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tdps_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [tdps_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tdps_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import tdps_pkg::*;

    logic [APB_DATA_W-1:0] r_tolerance;
    logic                  w_reg_sel;
    t_cmd                  w_cmd;
    t_stat                 w_stat;

    assign w_reg_sel = (paddr[APB_ADDR_W-1] == REG_TOLERANCE);
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? r_tolerance : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= '0;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_tolerance <= pwdata;
        end
    end

    tdps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tdps_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_tolerance (r_tolerance),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/tdps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tdps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tdps_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdps_datapath
// Point table, distance pipeline, stored count and output register.
// ----------------------------------------------------------------------------
module tdps_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tdps_pkg::t_in_item  i_in_data,
    input  logic [31:0]         i_tolerance,
    input  tdps_pkg::t_cmd      i_cmd,
    output tdps_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tdps_pkg::t_out_item o_out_data
);
    import tdps_pkg::*;

    function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W:0] a,
                                                    logic signed [COORD_W:0] b);
        logic signed [COORD_W:0] dif;
        logic signed [COORD_W:0] neg;
        dif = a - b;
        neg = b - a;
        return dif[COORD_W] ? neg[COORD_W-1:0] : dif[COORD_W-1:0];
    endfunction

    t_in_item         r_req;
    logic [CNT_W-1:0] r_count;
    logic             r_dup;
    logic [SQ_W-1:0]  r_eps_sq;

    logic             r_v0, r_v1, r_v2, r_v3;
    logic [COORD_W-1:0] r_dx, r_dy, r_dr;
    logic [SQ_W-1:0]  r_sq_x, r_sq_y, r_sq_r;
    logic             r_far2, r_far3;
    logic [SUM_W-1:0] r_sum;

    t_out_item        r_out;
    logic             r_out_valid;

    logic [ENTRY_W-1:0] w_rdata;
    t_entry             w_rd;
    logic [IDX_W-1:0]   w_raddr;
    logic               w_match;
    logic               w_full;
    logic               w_in_range;
    logic               w_store;
    logic               w_out_free;
    t_out_item          w_res;
    logic [SQ_W-1:0]    w_eps_sq;
    logic [SQ_W-1:0]    w_sq_x, w_sq_y, w_sq_r;
    t_entry             w_wentry;

    assign w_rd       = t_entry'(w_rdata);
    assign w_raddr    = i_cmd.scan ? i_cmd.scan_addr : r_req.read_index[IDX_W-1:0];
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_in_range = (CNT_W'(r_req.read_index) < r_count);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_store    = i_cmd.load_out && (r_req.req_type == REQ_INSERT)
                        && !r_dup && !w_full;

    assign w_wentry.x = r_req.center_x;
    assign w_wentry.y = r_req.center_y;
    assign w_wentry.r = r_req.radius_in;

    tdps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wentry),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_eps_sq = i_tolerance * i_tolerance;
    assign w_sq_x   = r_dx * r_dx;
    assign w_sq_y   = r_dy * r_dy;
    assign w_sq_r   = r_dr * r_dr;

    assign w_match = r_v3 && !r_far3 && (r_sum[SUM_W-1:SQ_W] == 2'b00)
                     && (r_sum[SQ_W-1:0] <= r_eps_sq);

    // distance pipeline: read -> abs diff -> square -> sum -> compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.rd_en && i_cmd.scan;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eps_sq <= w_eps_sq;
        r_dx     <= abs_diff({w_rd.x[COORD_W-1], w_rd.x},
                             {r_req.center_x[COORD_W-1], r_req.center_x});
        r_dy     <= abs_diff({w_rd.y[COORD_W-1], w_rd.y},
                             {r_req.center_y[COORD_W-1], r_req.center_y});
        r_dr     <= abs_diff({2'b00, w_rd.r}, {2'b00, r_req.radius_in});
        r_far2   <= (r_dx > i_tolerance) || (r_dy > i_tolerance)
                    || (r_dr > i_tolerance);
        r_sq_x   <= w_sq_x;
        r_sq_y   <= w_sq_y;
        r_sq_r   <= w_sq_r;
        r_far3   <= r_far2;
        r_sum    <= {2'b00, r_sq_x} + {2'b00, r_sq_y} + {2'b00, r_sq_r};
        if (i_cmd.start) begin
            r_req <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup <= 1'b0;
        end else if (i_cmd.start) begin
            r_dup <= 1'b0;
        end else if (w_match) begin
            r_dup <= 1'b1;
        end
    end

    always_comb begin
        w_res             = '0;
        w_res.entry_count = r_count;
        if (r_req.req_type == REQ_READ) begin
            if (w_in_range) begin
                w_res.status     = STATUS_READ_OK;
                w_res.out_x      = w_rd.x;
                w_res.out_y      = w_rd.y;
                w_res.out_radius = w_rd.r;
            end else begin
                w_res.status = STATUS_BAD_INDEX;
            end
        end else if (r_dup) begin
            w_res.status = STATUS_DUPLICATE;
        end else if (w_full) begin
            w_res.status = STATUS_FULL;
        end else begin
            w_res.status      = STATUS_STORED;
            w_res.entry_count = CNT_W'(r_count + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_store) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= w_res;
        end
    end

    assign o_stat.count         = r_count;
    assign o_stat.pipe_busy     = r_v0 || r_v1 || r_v2 || r_v3;
    assign o_stat.out_free      = w_out_free;
    assign o_stat.req_is_read   = (r_req.req_type == REQ_READ);
    assign o_stat.read_in_range = w_in_range;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_cmd.load_out) |=> $stable(r_count))
        else $error("stored count changed without a result");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !o_stat.pipe_busy)
        else $error("result loaded while compare pipeline busy");
`endif

endmodule

// ===== sv/tdps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdps_ctrl
// Request sequencer: dispatch, table scan, result hand-off.
// ----------------------------------------------------------------------------
module tdps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tdps_pkg::t_stat i_stat,
    output tdps_pkg::t_cmd  o_cmd
);
    import tdps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_SCAN     = 5'b00100,
        S_DECIDE   = 5'b01000,
        S_RDWAIT   = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_scan_cnt, n_scan_cnt;
    t_cmd             w_cmd;

    always_comb begin
        n_state    = r_state;
        n_scan_cnt = r_scan_cnt;
        w_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.start = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.req_is_read) begin
                    w_cmd.rd_en = i_stat.read_in_range;
                    n_state     = S_RDWAIT;
                end else begin
                    n_scan_cnt = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // one table read per cycle, then let the compare pipe drain
                if (r_scan_cnt < i_stat.count) begin
                    w_cmd.rd_en     = 1'b1;
                    w_cmd.scan      = 1'b1;
                    w_cmd.scan_addr = r_scan_cnt[IDX_W-1:0];
                    n_scan_cnt      = CNT_W'(r_scan_cnt + 1'b1);
                end else if (!i_stat.pipe_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE, S_RDWAIT: begin
                if (i_stat.out_free) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_scan_cnt <= n_scan_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = w_cmd;

`ifndef ASSERT_OFF
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.rd_en && w_cmd.scan) |-> (CNT_W'(w_cmd.scan_addr) < i_stat.count))
        else $error("scan read beyond stored entries");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |=> (o_in_stall && !w_cmd.load_out))
        else $error("request not held after transfer");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (i_stat.out_free && (n_state == S_IDLE)))
        else $error("result loaded into occupied output");
`endif

endmodule

// ===== test/tolerance_dedup_point_set_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerance_dedup_point_set_test
// Drives insert and read requests into the point set and compares every
// result against an in-bench model of the table, the entry count and the
// tolerance register. Covers empty and full table, distance boundaries,
// extreme coordinates, tolerance extremes and output backpressure.
// ----------------------------------------------------------------------------
module tolerance_dedup_point_set_test;
    import tdps_pkg::*;

    localparam int     HOLD_CYCLES = 400;
    localparam int     SETTLE      = 8;
    localparam longint TIMEOUT_NS  = 64'd40_000_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tolerance_dedup_point_set i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // model of the point set
    t_entry      tbl [CAPACITY];
    int unsigned tbl_count = 0;
    logic [31:0] tol_reg   = '0;

    t_out_item   expected_results [$];
    int unsigned mismatch_count = 0;

    // idling controls
    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;
    int unsigned hold_req   = 0;
    int unsigned hold_ack   = 0;
    int unsigned hold_left  = 0;
    int unsigned burst_left = 0;

    function automatic longint unsigned abs_gap(longint a, longint b);
        return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function automatic logic within_tol(t_entry e, t_in_item it);
        longint unsigned eps;
        longint unsigned d [3];
        logic [65:0]     acc;
        eps  = tol_reg;
        acc  = '0;
        d[0] = abs_gap($signed(e.x), $signed(it.center_x));
        d[1] = abs_gap($signed(e.y), $signed(it.center_y));
        d[2] = abs_gap(e.r, it.radius_in);
        for (int k = 0; k < 3; k++) begin
            if (d[k] > eps)
                return 1'b0;
            acc = acc + 66'(d[k] * d[k]);
        end
        return acc <= 66'(eps * eps);
    endfunction

    function automatic t_out_item dedup_predict(t_in_item it);
        t_out_item res;
        logic      dup;
        res = '0;
        dup = 1'b0;
        if (it.req_type == REQ_INSERT) begin
            for (int i = 0; i < tbl_count && !dup; i++)
                dup = within_tol(tbl[i], it);
            if (dup) begin
                res.status = STATUS_DUPLICATE;
            end else if (tbl_count >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                tbl[tbl_count].x = it.center_x;
                tbl[tbl_count].y = it.center_y;
                tbl[tbl_count].r = it.radius_in;
                tbl_count++;
                res.status = STATUS_STORED;
            end
        end else if (it.read_index < tbl_count) begin
            res.status     = STATUS_READ_OK;
            res.out_x      = tbl[it.read_index].x;
            res.out_y      = tbl[it.read_index].y;
            res.out_radius = tbl[it.read_index].r;
        end else begin
            res.status = STATUS_BAD_INDEX;
        end
        res.entry_count = 9'(tbl_count);
        return res;
    endfunction

    function automatic t_in_item insert_req(logic [31:0] x, logic [31:0] y, logic [30:0] r);
        t_in_item it;
        it            = '0;
        it.req_type   = REQ_INSERT;
        it.center_x   = x;
        it.center_y   = y;
        it.radius_in  = r;
        it.read_index = 8'($urandom());
        return it;
    endfunction

    function automatic t_in_item read_req(logic [7:0] idx);
        t_in_item it;
        logic [31:0] w;
        w             = $urandom();
        it.req_type   = REQ_READ;
        it.center_x   = $urandom();
        it.center_y   = $urandom();
        it.radius_in  = w[30:0];
        it.read_index = idx;
        return it;
    endfunction

    function automatic logic [31:0] nudge(logic [31:0] v, logic [31:0] spread);
        logic [31:0] off;
        off = $urandom_range(0, spread);
        return $urandom_range(0, 1) ? v + off : v - off;
    endfunction

    // inserts mostly near stored ones, scaled to the tolerance, so that
    // drops, stores and the distance boundary all come up
    function automatic t_in_item random_request(int unsigned read_pct);
        t_in_item    it;
        logic [31:0] w;
        logic [63:0] spread;
        t_entry      base;
        w  = $urandom();
        it = insert_req($urandom(), $urandom(), w[30:0]);
        if ($urandom_range(0, 99) < read_pct) begin
            if ($urandom_range(0, 3) == 0)
                it = read_req(8'($urandom()));
            else
                it = read_req(8'($urandom_range(0, tbl_count)));
        end else if (tbl_count != 0 && $urandom_range(0, 9) < 7) begin
            base   = tbl[$urandom_range(0, tbl_count - 1)];
            spread = (64'(tol_reg) * $urandom_range(0, 3)) / 2;
            if (spread > 64'hFFFF_FFFF)
                spread = 64'hFFFF_FFFF;
            it.center_x  = nudge(base.x, spread[31:0]);
            it.center_y  = nudge(base.y, spread[31:0]);
            w            = nudge({1'b0, base.r}, spread[31:0]);
            it.radius_in = w[30:0];
        end
        return it;
    endfunction

    task automatic send_request(t_in_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(dedup_predict(it));
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_idling(int unsigned gap, int unsigned stall);
        gap_pct   = gap;
        stall_pct <= stall;
    endtask

    // write the tolerance register while idle, then read it back
    task automatic set_tolerance(logic [31:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TOLERANCE, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tol_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("tolerance readback: expected %h actual %h", value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver stall: random bursts plus an on-demand long hold
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (burst_left != 0) begin
            burst_left--;
            out_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            burst_left = $urandom_range(1, 6) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %p", out_data);
            end else begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status || out_data.out_x !== want.out_x
                        || out_data.out_y !== want.out_y
                        || out_data.out_radius !== want.out_radius
                        || out_data.entry_count !== want.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: status %0d/%0d x %h/%h y %h/%h ",
                                  "radius %h/%h count %0d/%0d (expected/actual)"},
                                 want.status, out_data.status, want.out_x, out_data.out_x,
                                 want.out_y, out_data.out_y, want.out_radius,
                                 out_data.out_radius, want.entry_count,
                                 out_data.entry_count);
                end
            end
        end
    end

    task automatic test_empty_and_extremes();
        set_idling(20, 20);
        send_request(read_req(8'd0));
        send_request(read_req(8'd255));
        send_request(insert_req(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_request(insert_req(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_request(insert_req(32'h7FFF_FFFF, 32'h8000_0000, 31'h0));
        send_request(insert_req(32'h0, 32'h0, 31'h0));
        send_request(insert_req(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFE));
        for (int i = 0; i < 5; i++)
            send_request(read_req(8'(i)));
        send_request(read_req(8'd255));
        drain_results();
    endtask

    task automatic test_tolerance_boundary();
        set_tolerance(32'h0001_0000);
        // exactly eps away along one axis still counts as a match
        send_request(insert_req(32'h0001_0000, 32'h0, 31'h0));
        send_request(insert_req(32'h0001_0001, 32'h0, 31'h0));
        // each axis within eps, summed squares just inside / just outside
        send_request(insert_req(-32'sd46340, -32'sd46340, 31'h0));
        send_request(insert_req(-32'sd46341, -32'sd46341, 31'h0));
        send_request(read_req(8'd5));
        send_request(read_req(8'd6));
        set_tolerance(32'hFFFF_FFFF);
        send_request(insert_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h5));
        send_request(insert_req(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
        send_request(read_req(8'd7));
        drain_results();
    endtask

    task automatic test_output_backpressure();
        set_tolerance(32'h0000_0100);
        set_idling(0, 0);
        drain_results();
        hold_req <= hold_req + 1;
        for (int i = 0; i < 20; i++)
            send_request(random_request(60));
        // sender waits here until every result is out
        drain_results();
        for (int i = 0; i < 10; i++)
            send_request(random_request(50));
        drain_results();
    endtask

    task automatic test_random_growth();
        logic [31:0] tols [6];
        tols = '{32'h0, 32'h1, 32'h0000_0100, 32'h0001_0000, $urandom(), 32'hFFFF_FFFF};
        for (int p = 0; p < 6; p++) begin
            set_tolerance(tols[p]);
            case (p % 4)
                0: set_idling(20, 20);
                1: set_idling(0, 0);
                2: set_idling(40, 10);
                default: set_idling(10, 40);
            endcase
            for (int i = 0; i < 150; i++)
                send_request(random_request(40));
        end
        drain_results();
    endtask

    task automatic test_full_table();
        logic [31:0] w;
        set_tolerance(32'h0);
        set_idling(15, 15);
        while (tbl_count < CAPACITY) begin
            w = $urandom();
            send_request(insert_req($urandom(), $urandom(), w[30:0]));
        end
        // full and matching reports the drop, full and new reports full
        send_request(insert_req(tbl[0].x, tbl[0].y, tbl[0].r));
        send_request(insert_req(tbl[255].x, tbl[255].y, tbl[255].r));
        w = $urandom();
        send_request(insert_req($urandom(), $urandom(), w[30:0]));
        send_request(read_req(8'd0));
        send_request(read_req(8'd255));
        drain_results();
    endtask

    task automatic test_random_full();
        set_tolerance($urandom());
        set_idling(25, 25);
        for (int i = 0; i < 250; i++)
            send_request(random_request(40));
        set_tolerance(32'hFFFF_FFFF);
        set_idling(10, 30);
        for (int i = 0; i < 250; i++)
            send_request(random_request(40));
        // closing stretch without any idling
        set_tolerance(32'h0000_0100);
        set_idling(0, 0);
        for (int i = 0; i < 300; i++)
            send_request(random_request(40));
        drain_results();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_extremes();
        test_tolerance_boundary();
        test_output_backpressure();
        test_random_growth();
        test_full_table();
        test_random_full();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
